>>> rtl/bclp_pkg.sv
// Shared types and constants of the button click and long press classifier.
`default_nettype none
package bclp_pkg;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 40;
    localparam int DEB_WIDTH       = 8;
    localparam int THR_WIDTH       = 16;
    localparam int MAP_WIDTH       = 40;
    localparam int EV_WIDTH        = 3;
    localparam int FUNC_WIDTH      = 4;
    localparam int BIDX_WIDTH      = 2;
    localparam int PIN_WIDTH       = 4;
    localparam int CLICK_WIDTH     = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG      = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POWER     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT   = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAP_LOW   = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAP_HIGH  = 3'd6;

    localparam logic [DEB_WIDTH-1:0] RST_DEBOUNCE = 8'd5;
    localparam logic [THR_WIDTH-1:0] RST_LONG     = 16'd300;
    localparam logic [THR_WIDTH-1:0] RST_POWER    = 16'd500;
    localparam logic [THR_WIDTH-1:0] RST_RESET    = 16'd1000;
    localparam logic [THR_WIDTH-1:0] RST_TIMEOUT  = 16'd40;
    localparam logic [MAP_WIDTH-1:0] RST_MAP      = 40'd366197691441;

    localparam logic [EV_WIDTH-1:0] EV_CLICK  = 3'd0;
    localparam logic [EV_WIDTH-1:0] EV_DOUBLE = 3'd1;
    localparam logic [EV_WIDTH-1:0] EV_TRIPLE = 3'd2;
    localparam logic [EV_WIDTH-1:0] EV_LONG   = 3'd3;
    localparam logic [EV_WIDTH-1:0] EV_POWER  = 3'd4;
    localparam logic [EV_WIDTH-1:0] EV_RESET  = 3'd5;

    localparam logic [CLICK_WIDTH-1:0] CLICK_MAX = 2'd3;
    localparam logic [CLICK_WIDTH-1:0] CLICK_TWO = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic event_found;
        logic pend_valid;
        logic out_free;
        logic last_button;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/bclp_ctrl.sv
// Sequencer that walks the buttons of one tick and flushes the held event.
`default_nettype none
module bclp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire bclp_pkg::t_status i_status,
    output bclp_pkg::t_cmd        o_cmd,
    output logic                  o_in_stall
);

    bclp_pkg::t_state r_state;
    bclp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bclp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            bclp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bclp_pkg::ST_STEP;
                end
            end
            bclp_pkg::ST_STEP: begin
                // hold while a new event would overwrite an item that cannot leave
                if (!(i_status.event_found && i_status.pend_valid && !i_status.out_free)) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_button) begin
                        n_state = bclp_pkg::ST_FLUSH;
                    end
                end
            end
            bclp_pkg::ST_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = bclp_pkg::ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = bclp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bclp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/bclp_datapath.sv
// Configuration registers, per-button state, event classifier and output register.
`default_nettype none
module bclp_datapath #(
    parameter int BUTTONS    = 4,
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [bclp_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [bclp_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data,
    input  wire logic [bclp_pkg::PIN_WIDTH-1:0]        i_pin_levels,
    input  wire bclp_pkg::t_cmd                        i_cmd,
    output bclp_pkg::t_status                          o_status,
    input  wire logic                                  i_out_stall,
    output logic                                       o_out_valid,
    output logic [bclp_pkg::BIDX_WIDTH-1:0]            o_button_index,
    output logic [bclp_pkg::EV_WIDTH-1:0]              o_event_code,
    output logic [bclp_pkg::FUNC_WIDTH-1:0]            o_function_code,
    output logic                                       o_last_in_tick
);

    localparam int IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CW = (TIME_WIDTH > bclp_pkg::THR_WIDTH) ? TIME_WIDTH : bclp_pkg::THR_WIDTH;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    // configuration
    logic [bclp_pkg::DEB_WIDTH-1:0] r_deb_ticks;
    logic [bclp_pkg::THR_WIDTH-1:0] r_long_ticks;
    logic [bclp_pkg::THR_WIDTH-1:0] r_power_ticks;
    logic [bclp_pkg::THR_WIDTH-1:0] r_reset_ticks;
    logic [bclp_pkg::THR_WIDTH-1:0] r_timeout_ticks;
    logic [bclp_pkg::MAP_WIDTH-1:0] r_map_low;
    logic [bclp_pkg::MAP_WIDTH-1:0] r_map_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb_ticks     <= bclp_pkg::RST_DEBOUNCE;
            r_long_ticks    <= bclp_pkg::RST_LONG;
            r_power_ticks   <= bclp_pkg::RST_POWER;
            r_reset_ticks   <= bclp_pkg::RST_RESET;
            r_timeout_ticks <= bclp_pkg::RST_TIMEOUT;
            r_map_low       <= bclp_pkg::RST_MAP;
            r_map_high      <= bclp_pkg::RST_MAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bclp_pkg::REG_DEBOUNCE: r_deb_ticks     <= i_cfg_data[bclp_pkg::DEB_WIDTH-1:0];
                bclp_pkg::REG_LONG:     r_long_ticks    <= i_cfg_data[bclp_pkg::THR_WIDTH-1:0];
                bclp_pkg::REG_POWER:    r_power_ticks   <= i_cfg_data[bclp_pkg::THR_WIDTH-1:0];
                bclp_pkg::REG_RESET:    r_reset_ticks   <= i_cfg_data[bclp_pkg::THR_WIDTH-1:0];
                bclp_pkg::REG_TIMEOUT:  r_timeout_ticks <= i_cfg_data[bclp_pkg::THR_WIDTH-1:0];
                bclp_pkg::REG_MAP_LOW:  r_map_low       <= i_cfg_data[bclp_pkg::MAP_WIDTH-1:0];
                bclp_pkg::REG_MAP_HIGH: r_map_high      <= i_cfg_data[bclp_pkg::MAP_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick sample and button walk
    logic [BUTTONS-1:0] r_pressed;
    logic [IW-1:0]      r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.step && (r_idx != IW'(BUTTONS - 1))) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pressed <= ~i_pin_levels[BUTTONS-1:0];
        end
    end

    // per-button state
    logic                                r_raw   [BUTTONS];
    logic [bclp_pkg::DEB_WIDTH-1:0]      r_sc    [BUTTONS];
    logic                                r_deb   [BUTTONS];
    logic                                r_prev  [BUTTONS];
    logic [TIME_WIDTH-1:0]               r_hold  [BUTTONS];
    logic [bclp_pkg::CLICK_WIDTH-1:0]    r_cc    [BUTTONS];
    logic [TIME_WIDTH-1:0]               r_since [BUTTONS];

    logic                             c_pressed;
    logic                             n_raw;
    logic [bclp_pkg::DEB_WIDTH-1:0]   n_sc;
    logic                             n_deb;
    logic                             n_prev;
    logic [TIME_WIDTH-1:0]            n_hold;
    logic [bclp_pkg::CLICK_WIDTH-1:0] n_cc;
    logic [TIME_WIDTH-1:0]            n_since;
    logic                             c_event;
    logic [bclp_pkg::EV_WIDTH-1:0]    c_ev;
    logic                             c_clicked;
    logic [CW-1:0]                    c_dur;
    logic [bclp_pkg::BIDX_WIDTH-1:0]  c_bidx;
    logic [bclp_pkg::MAP_WIDTH-1:0]   c_map;
    logic [5:0]                       c_off;
    logic [bclp_pkg::FUNC_WIDTH-1:0]  c_func;

    always_comb begin
        c_pressed = r_pressed[r_idx];
        n_raw     = r_raw[r_idx];
        n_sc      = r_sc[r_idx];
        n_deb     = r_deb[r_idx];
        n_prev    = r_prev[r_idx];
        n_hold    = r_hold[r_idx];
        n_cc      = r_cc[r_idx];
        n_since   = r_since[r_idx];
        c_event   = 1'b0;
        c_ev      = bclp_pkg::EV_CLICK;
        c_clicked = 1'b0;

        if (c_pressed != n_raw) begin
            n_raw = c_pressed;
            n_sc  = '0;
        end else if (n_sc >= r_deb_ticks) begin
            n_deb = n_raw;
        end else begin
            n_sc = n_sc + 1'b1;
        end

        if (n_prev && (n_hold != TIME_MAX)) begin
            n_hold = n_hold + 1'b1;
        end
        if (n_deb && !n_prev) begin
            n_hold = '0;
            n_prev = 1'b1;
        end

        c_dur = CW'(n_hold);
        if (!n_deb && n_prev) begin
            if (c_dur < CW'(r_long_ticks)) begin
                if (n_cc != bclp_pkg::CLICK_MAX) begin
                    n_cc = n_cc + 1'b1;
                end
                n_since   = '0;
                c_clicked = 1'b1;
                if (n_cc == bclp_pkg::CLICK_MAX) begin
                    c_event = 1'b1;
                    c_ev    = bclp_pkg::EV_TRIPLE;
                    n_cc    = '0;
                end
            end else begin
                c_event = 1'b1;
                if (c_dur < CW'(r_power_ticks)) begin
                    c_ev = bclp_pkg::EV_LONG;
                end else if (c_dur < CW'(r_reset_ticks)) begin
                    c_ev = bclp_pkg::EV_POWER;
                end else begin
                    c_ev = bclp_pkg::EV_RESET;
                end
                n_cc = '0;
            end
            n_prev = 1'b0;
        end

        if (!c_clicked && (n_cc != '0)) begin
            if (CW'(n_since) >= CW'(r_timeout_ticks)) begin
                c_event = 1'b1;
                c_ev    = (n_cc == bclp_pkg::CLICK_TWO) ? bclp_pkg::EV_DOUBLE
                                                        : bclp_pkg::EV_CLICK;
                n_cc    = '0;
            end else if (n_since != TIME_MAX) begin
                n_since = n_since + 1'b1;
            end
        end

        c_bidx = bclp_pkg::BIDX_WIDTH'(r_idx);
        c_map  = c_bidx[1] ? r_map_high : r_map_low;
        c_off  = (c_bidx[0] ? 6'd20 : 6'd0) + {1'b0, c_ev, 2'b00};
        c_func = (c_ev == bclp_pkg::EV_RESET) ? '0 : c_map[c_off +: bclp_pkg::FUNC_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BUTTONS; b++) begin
                r_raw[b]   <= 1'b0;
                r_sc[b]    <= '0;
                r_deb[b]   <= 1'b0;
                r_prev[b]  <= 1'b0;
                r_hold[b]  <= '0;
                r_cc[b]    <= '0;
                r_since[b] <= '0;
            end
        end else if (i_cmd.step) begin
            r_raw[r_idx]   <= n_raw;
            r_sc[r_idx]    <= n_sc;
            r_deb[r_idx]   <= n_deb;
            r_prev[r_idx]  <= n_prev;
            r_hold[r_idx]  <= n_hold;
            r_cc[r_idx]    <= n_cc;
            r_since[r_idx] <= n_since;
        end
    end

    // one event held back until the next one shows whether it is the last
    logic                            r_pend_valid;
    logic [bclp_pkg::BIDX_WIDTH-1:0] r_pend_bidx;
    logic [bclp_pkg::EV_WIDTH-1:0]   r_pend_ev;
    logic [bclp_pkg::FUNC_WIDTH-1:0] r_pend_func;
    logic                            c_out_free;
    logic                            c_push_mid;
    logic                            c_push_out;

    assign c_out_free = !o_out_valid || !i_out_stall;
    assign c_push_mid = i_cmd.step && c_event && r_pend_valid;
    assign c_push_out = c_push_mid || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.load || i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && c_event) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && c_event) begin
            r_pend_bidx <= c_bidx;
            r_pend_ev   <= c_ev;
            r_pend_func <= c_func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (c_push_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push_out) begin
            o_button_index  <= r_pend_bidx;
            o_event_code    <= r_pend_ev;
            o_function_code <= r_pend_func;
            o_last_in_tick  <= i_cmd.flush;
        end
    end

    assign o_status.event_found = c_event;
    assign o_status.pend_valid  = r_pend_valid;
    assign o_status.out_free    = c_out_free;
    assign o_status.last_button = (r_idx == IW'(BUTTONS - 1));

endmodule
`default_nettype wire

>>> rtl/button_click_long_press_classifier.sv
// Top level of the button click and long press classifier.
// Each accepted item is one sample tick of the active-low button pins, and a new
// tick is stalled until the last one is through. For each tick the block captures
// the pins, the sequencer walks each button in turn through the shared debounce and
// classify logic, and then the held last event of the tick is released. Each button
// gives at most one event per tick; events leave through an output register, and a
// stalled output holds the button walk. The user must make configuration writes only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module button_click_long_press_classifier #(
    parameter int BUTTONS    = 4,
    parameter int TIME_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [bclp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [bclp_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [bclp_pkg::PIN_WIDTH-1:0]       i_pin_levels,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [bclp_pkg::BIDX_WIDTH-1:0]           o_button_index,
    output logic [bclp_pkg::EV_WIDTH-1:0]             o_event_code,
    output logic [bclp_pkg::FUNC_WIDTH-1:0]           o_function_code,
    output logic                                      o_last_in_tick
);

    bclp_pkg::t_cmd    w_cmd;
    bclp_pkg::t_status w_status;

    bclp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    bclp_datapath #(
        .BUTTONS    (BUTTONS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pin_levels    (i_pin_levels),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_button_index  (o_button_index),
        .o_event_code    (o_event_code),
        .o_function_code (o_function_code),
        .o_last_in_tick  (o_last_in_tick)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the button click and long press classifier: directed plan, random gestures.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bclp_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam logic [THR_WIDTH-1:0] TIME_MAX = '1;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_TICKS = 30;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BIDX_WIDTH-1:0] button;
        logic [EV_WIDTH-1:0]   code;
        logic [FUNC_WIDTH-1:0] func;
        logic                  last_flag;
    } t_button_event;

    typedef enum logic {
        RK_TICK,
        RK_CFG
    } t_row_kind;

    typedef enum logic [1:0] {
        CK_PRED,
        CK_NONE,
        CK_EVENT
    } t_row_check;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [CFG_DATA_WIDTH-1:0]  val;
        int                    reps;
        t_row_check            chk;
        logic [EV_WIDTH-1:0]   ev;
    } t_plan_row;

    localparam int PLAN_LEN = 43;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{RK_TICK, '0, 40'hF, 3, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'h0, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 8, CK_NONE, EV_CLICK},
        '{RK_CFG, REG_MAP_LOW, 40'hFE_DCBA_9876, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_MAP_HIGH, 40'h10_F2E3_D4C5, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_DEBOUNCE, 40'hFF_FFFF_FF00, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_LONG, 40'hAB_CD00_0003, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_POWER, 40'h00_0001_0006, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_RESET, 40'd9, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_TIMEOUT, 40'd4, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_UNUSED, 40'hFF_FFFF_FFFF, 0, CK_PRED, EV_CLICK},
        '{RK_TICK, '0, 40'h0, 4, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_EVENT, EV_LONG},
        '{RK_TICK, '0, 40'h0, 7, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_EVENT, EV_POWER},
        '{RK_TICK, '0, 40'h0, 10, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_EVENT, EV_RESET},
        '{RK_TICK, '0, 40'hE, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 5, CK_EVENT, EV_CLICK},
        '{RK_TICK, '0, 40'hA, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hA, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 5, CK_EVENT, EV_DOUBLE},
        '{RK_TICK, '0, 40'h5, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'h5, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'h5, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_EVENT, EV_TRIPLE},
        '{RK_CFG, REG_LONG, 40'd8, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_POWER, 40'd4, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_RESET, 40'd6, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_TIMEOUT, 40'd30, 0, CK_PRED, EV_CLICK},
        '{RK_TICK, '0, 40'h0, 5, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'h0, 9, CK_NONE, EV_CLICK},
        '{RK_TICK, '0, 40'hF, 2, CK_EVENT, EV_RESET},
        '{RK_TICK, '0, 40'hF, 35, CK_NONE, EV_CLICK},
        '{RK_CFG, REG_LONG, 40'd65533, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_POWER, 40'd65534, 0, CK_PRED, EV_CLICK},
        '{RK_CFG, REG_RESET, 40'd65535, 0, CK_PRED, EV_CLICK}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic [PIN_WIDTH-1:0] i_pin_levels = '1;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic [BIDX_WIDTH-1:0] o_button_index;
    logic [EV_WIDTH-1:0] o_event_code;
    logic [FUNC_WIDTH-1:0] o_function_code;
    logic o_last_in_tick;

    logic [DEB_WIDTH-1:0] cfg_debounce = RST_DEBOUNCE;
    logic [THR_WIDTH-1:0] cfg_long = RST_LONG;
    logic [THR_WIDTH-1:0] cfg_power = RST_POWER;
    logic [THR_WIDTH-1:0] cfg_reset = RST_RESET;
    logic [THR_WIDTH-1:0] cfg_timeout = RST_TIMEOUT;
    logic [MAP_WIDTH-1:0] cfg_map_low = RST_MAP;
    logic [MAP_WIDTH-1:0] cfg_map_high = RST_MAP;

    logic                 raw_lvl [4] = '{default: 1'b0};
    logic [DEB_WIDTH-1:0] stable_cnt [4] = '{default: '0};
    logic                 deb_lvl [4] = '{default: 1'b0};
    logic                 held [4] = '{default: 1'b0};
    logic [THR_WIDTH-1:0] hold_cnt [4] = '{default: '0};
    logic [CLICK_WIDTH-1:0] click_cnt [4] = '{default: '0};
    logic [THR_WIDTH-1:0] since_cnt [4] = '{default: '0};

    t_button_event expected_events [$];
    t_button_event want;
    t_button_event got;
    int failures = 0;
    int events_checked = 0;
    int ticks_sent = 0;
    int cycles = 0;
    int in_idle_pct = 29;
    int out_idle_pct = 29;

    button_click_long_press_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pin_levels    (i_pin_levels),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_button_index  (o_button_index),
        .o_event_code    (o_event_code),
        .o_function_code (o_function_code),
        .o_last_in_tick  (o_last_in_tick)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycles, expected_events.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("FAIL: %s", msg);
    endfunction

    function automatic int classify_tick(input logic [PIN_WIDTH-1:0] pins,
                                         output logic [EV_WIDTH-1:0] first_ev);
        int n;
        int b;
        logic pressed;
        logic clicked;
        logic fire;
        logic [EV_WIDTH-1:0] ev;
        logic [MAP_WIDTH-1:0] fmap;
        t_button_event item;
        n = 0;
        first_ev = EV_CLICK;
        for (b = 0; b < 4; b++) begin
            pressed = ~pins[b];
            clicked = 1'b0;
            fire = 1'b0;
            ev = EV_CLICK;
            if (pressed != raw_lvl[b]) begin
                raw_lvl[b] = pressed;
                stable_cnt[b] = '0;
            end else if (stable_cnt[b] >= cfg_debounce) begin
                deb_lvl[b] = raw_lvl[b];
            end else begin
                stable_cnt[b]++;
            end
            if (held[b] && hold_cnt[b] != TIME_MAX)
                hold_cnt[b]++;
            if (deb_lvl[b] && !held[b]) begin
                hold_cnt[b] = '0;
                held[b] = 1'b1;
            end
            if (!deb_lvl[b] && held[b]) begin
                if (hold_cnt[b] < cfg_long) begin
                    if (click_cnt[b] != CLICK_MAX)
                        click_cnt[b]++;
                    since_cnt[b] = '0;
                    clicked = 1'b1;
                    if (click_cnt[b] == CLICK_MAX) begin
                        fire = 1'b1;
                        ev = EV_TRIPLE;
                        click_cnt[b] = '0;
                    end
                end else begin
                    fire = 1'b1;
                    if (hold_cnt[b] < cfg_power)
                        ev = EV_LONG;
                    else if (hold_cnt[b] < cfg_reset)
                        ev = EV_POWER;
                    else
                        ev = EV_RESET;
                    click_cnt[b] = '0;
                end
                held[b] = 1'b0;
            end
            if (!clicked && click_cnt[b] != '0) begin
                if (since_cnt[b] >= cfg_timeout) begin
                    fire = 1'b1;
                    ev = (click_cnt[b] == CLICK_TWO) ? EV_DOUBLE : EV_CLICK;
                    click_cnt[b] = '0;
                end else if (since_cnt[b] != TIME_MAX) begin
                    since_cnt[b]++;
                end
            end
            if (fire) begin
                fmap = (b < 2) ? cfg_map_low : cfg_map_high;
                item.button = BIDX_WIDTH'(b);
                item.code = ev;
                item.func = (ev > EV_POWER) ? '0 :
                            FUNC_WIDTH'(fmap >> (20 * (b % 2) + 4 * int'(ev)));
                item.last_flag = 1'b0;
                if (n == 0)
                    first_ev = ev;
                expected_events.push_back(item);
                n++;
            end
        end
        if (n > 0)
            expected_events[expected_events.size() - 1].last_flag = 1'b1;
        return n;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_button_index, o_event_code, o_function_code, o_last_in_tick};
            if (expected_events.size() == 0) begin
                note_failure($sformatf({"unexpected event: button %0d code %0d ",
                                        "func %0d last %0d"},
                                       got.button, got.code, got.func, got.last_flag));
            end else begin
                want = expected_events.pop_front();
                events_checked++;
                if (got !== want)
                    note_failure($sformatf({"event mismatch: expected button %0d code %0d ",
                                            "func %0d last %0d, got %0d %0d %0d %0d"},
                                           want.button, want.code, want.func, want.last_flag,
                                           got.button, got.code, got.func, got.last_flag));
            end
        end
    end

    task automatic send_tick(input logic [PIN_WIDTH-1:0] pins, output int produced,
                             output logic [EV_WIDTH-1:0] first_ev);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (o_in_stall);
        produced = classify_tick(pins, first_ev);
        ticks_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_DEBOUNCE: cfg_debounce = data[DEB_WIDTH-1:0];
            REG_LONG:     cfg_long = data[THR_WIDTH-1:0];
            REG_POWER:    cfg_power = data[THR_WIDTH-1:0];
            REG_RESET:    cfg_reset = data[THR_WIDTH-1:0];
            REG_TIMEOUT:  cfg_timeout = data[THR_WIDTH-1:0];
            REG_MAP_LOW:  cfg_map_low = data[MAP_WIDTH-1:0];
            REG_MAP_HIGH: cfg_map_high = data[MAP_WIDTH-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [DEB_WIDTH-1:0] deb, input logic [THR_WIDTH-1:0] lp,
                             input logic [THR_WIDTH-1:0] pw, input logic [THR_WIDTH-1:0] rs,
                             input logic [THR_WIDTH-1:0] to, input logic [MAP_WIDTH-1:0] ml,
                             input logic [MAP_WIDTH-1:0] mh, input int idle);
        logic [PIN_WIDTH-1:0] held_mask;
        logic [PIN_WIDTH-1:0] pins;
        logic [EV_WIDTH-1:0] first_ev;
        int span;
        int gap;
        int produced;
        int first_tick;
        wait_drained();
        cfg_write(REG_DEBOUNCE, CFG_DATA_WIDTH'(deb));
        cfg_write(REG_LONG, CFG_DATA_WIDTH'(lp));
        cfg_write(REG_POWER, CFG_DATA_WIDTH'(pw));
        cfg_write(REG_RESET, CFG_DATA_WIDTH'(rs));
        cfg_write(REG_TIMEOUT, CFG_DATA_WIDTH'(to));
        cfg_write(REG_MAP_LOW, ml);
        cfg_write(REG_MAP_HIGH, mh);
        in_idle_pct = idle;
        out_idle_pct = idle;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < PHASE_TICKS) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 6))
                    send_tick(PIN_WIDTH'($urandom()), produced, first_ev);
            end else begin
                held_mask = PIN_WIDTH'($urandom_range(1, 15));
                span = int'(cfg_debounce) + 3 + ((cfg_reset > 20) ? 20 : int'(cfg_reset));
                gap = int'(cfg_debounce) + 2 + ((cfg_timeout > 12) ? 12 : int'(cfg_timeout));
                repeat ($urandom_range(1, span)) begin
                    pins = ~held_mask;
                    if ($urandom_range(0, 99) < 8)
                        pins[2'($urandom_range(0, 3))] ^= 1'b1;
                    send_tick(pins, produced, first_ev);
                end
                repeat ($urandom_range(1, gap))
                    send_tick('1, produced, first_ev);
            end
        end
    endtask

    initial begin
        int r;
        int k;
        int produced;
        logic [EV_WIDTH-1:0] first_ev;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].kind == RK_CFG) begin
                wait_drained();
                cfg_write(PLAN[r].idx, PLAN[r].val);
            end else begin
                for (k = 0; k < PLAN[r].reps; k++) begin
                    send_tick(PLAN[r].val[PIN_WIDTH-1:0], produced, first_ev);
                    if (PLAN[r].chk == CK_NONE ||
                        (PLAN[r].chk == CK_EVENT && k != PLAN[r].reps - 1)) begin
                        if (produced != 0)
                            note_failure($sformatf("plan row %0d tick %0d: %0d events, none wanted",
                                                   r, k, produced));
                    end else if (PLAN[r].chk == CK_EVENT) begin
                        if (produced == 0 || first_ev != PLAN[r].ev)
                            note_failure($sformatf({"plan row %0d: wanted event code %0d, ",
                                                    "got %0d of %0d"},
                                                   r, PLAN[r].ev, first_ev, produced));
                    end
                end
            end
        end

        wait_drained();
        cfg_write(REG_DEBOUNCE, 40'hAB_CDEF_01FF);
        for (k = 0; k < 12; k++)
            send_tick(4'hE, produced, first_ev);
        for (k = 0; k < 12; k++)
            send_tick('1, produced, first_ev);

        run_phase(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, '0, '1, 29);
        run_phase(8'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  MAP_WIDTH'({$urandom(), $urandom()}), MAP_WIDTH'({$urandom(), $urandom()}), 29);
        run_phase(DEB_WIDTH'($urandom_range(0, 3)), THR_WIDTH'($urandom_range(1, 10)),
                  THR_WIDTH'($urandom_range(1, 16)), THR_WIDTH'($urandom_range(1, 22)),
                  THR_WIDTH'($urandom_range(1, 12)), '1, '0, 0);
        repeat (3)
            run_phase(DEB_WIDTH'($urandom_range(0, 3)), THR_WIDTH'($urandom_range(1, 10)),
                      THR_WIDTH'($urandom_range(1, 16)), THR_WIDTH'($urandom_range(1, 22)),
                      THR_WIDTH'($urandom_range(1, 12)),
                      MAP_WIDTH'({$urandom(), $urandom()}), MAP_WIDTH'({$urandom(), $urandom()}),
                      29);

        wait_drained();
        $display("%0d sample ticks sent, %0d button events compared (%0d mismatches)",
                 ticks_sent, events_checked, failures);
        $display("covered: debounce 0 to 255, every event kind, misordered thresholds, stalls");
        if (failures == 0 && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
